// ----- rtl/abg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// abg_pkg
// Shared types and constants for the adjacent box grouping block.
// ----------------------------------------------------------------------------
package abg_pkg;

	localparam int MAX_BOXES  = 32;
	localparam int COORD_BITS = 16;
	localparam int IDX_BITS   = $clog2(MAX_BOXES);
	localparam int CNT_BITS   = $clog2(MAX_BOXES + 1);
	localparam int SIZE_BITS  = COORD_BITS - 1;
	localparam int EDGE_BITS  = COORD_BITS + 1;
	localparam int GAP_BITS   = COORD_BITS + 2;

	// configuration register indexes
	localparam logic CFG_GAP_X = 1'b0;
	localparam logic CFG_GAP_Y = 1'b1;

	// record kinds
	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_MEMBER = 1'b1;

	// datapath commands from the controller
	typedef struct packed {
		logic                store;     // write incoming box at load slot
		logic                clear;     // reset run state
		logic                rd_i;      // read box i into register a
		logic                rd_j;      // read box j into register b
		logic                test;      // evaluate link of a, b
		logic                find_i;    // step root search from i
		logic                link;      // parent[ri] = rj
		logic                slot_upd;  // finish group pass for box i
		logic [IDX_BITS-1:0] i;
		logic [IDX_BITS-1:0] j;
	} abg_cmd_t;

	typedef struct packed {
		logic                linked;    // last test result
		logic                find_done; // root search finished
		logic [IDX_BITS-1:0] root;
		logic [CNT_BITS-1:0] ngroups;
	} abg_sts_t;

endpackage
`default_nettype wire

// ----- rtl/adjacent_box_grouping.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adjacent_box_grouping
// Groups rectangles whose gaps fall below configured limits (union-find).
// ----------------------------------------------------------------------------
//  channel  | signals                          | direction
//  boxes    | box_valid/box_stall + box fields | in
//  records  | rec_valid/rec_stall + rec fields | out
//  config   | cfg_we, cfg_index, cfg_data      | in
//
// loading accepts one box per cycle while box_stall is low. after the last box
// each pair is read, tested and checked; when linked, the roots of i and j are
// searched and joined, using the single shared gap test and parent table.
// the group pass reads each box, searches its root and updates its group slot,
// then each group gives a header record and scans every stored box for members.
// boxes are held off by box_stall while a run is grouped, emitted and cleared.
// ----------------------------------------------------------------------------
module adjacent_box_grouping (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire               cfg_index,
	input  wire        [15:0] cfg_data,
	input  wire               box_valid,
	output logic              box_stall,
	input  wire signed [15:0] box_left,
	input  wire signed [15:0] box_top,
	input  wire signed [15:0] box_width,
	input  wire signed [15:0] box_height,
	input  wire               last_box,
	output logic              rec_valid,
	input  wire               rec_stall,
	output logic              record_kind,
	output logic        [4:0] group_number,
	output logic        [4:0] member_index,
	output logic        [5:0] member_count,
	output logic signed [15:0] union_left,
	output logic signed [15:0] union_top,
	output logic       [16:0] union_width,
	output logic       [16:0] union_height,
	output logic              overflow,
	output logic              last_record
);
	logic [15:0] gap_x_q, gap_y_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_x_q <= 16'd1; gap_y_q <= 16'd1;
		end else if (cfg_we) begin
			if (cfg_index == abg_pkg::CFG_GAP_X) gap_x_q <= cfg_data;
			else gap_y_q <= cfg_data;
		end
	end

	abg_pkg::abg_cmd_t cmd;
	abg_pkg::abg_sts_t sts;
	logic ready, in_fire, kind, last_r, ovf;
	logic [4:0] wr_idx, gsel, msel, mgrp;
	logic signed [15:0] gl, gt;
	logic [16:0] gw, gh;
	logic [5:0] gc;

	assign box_stall = !ready;
	assign in_fire = box_valid && ready;

	abg_control u_ctl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_last(last_box),
		.in_ready(ready), .cmd(cmd), .sts(sts), .wr_idx(wr_idx), .ovf(ovf),
		.out_grp(gsel), .out_mem(msel), .mem_group(mgrp), .grp_count(gc),
		.rec_valid(rec_valid), .rec_kind(kind), .rec_last(last_r),
		.rec_stall(rec_stall)
	);

	abg_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.gap_x(gap_x_q), .gap_y(gap_y_q),
		.in_left(box_left), .in_top(box_top), .in_width(box_width),
		.in_height(box_height), .wr_idx(wr_idx), .grp_sel(gsel), .mem_sel(msel),
		.mem_group(mgrp), .grp_left(gl), .grp_top(gt), .grp_width(gw),
		.grp_height(gh), .grp_count(gc)
	);

	// record fields, unused ones forced to zero
	assign record_kind  = kind;
	assign group_number = gsel;
	assign member_index = kind ? msel : 5'd0;
	assign member_count = kind ? 6'd0 : gc;
	assign union_left   = kind ? 16'sd0 : gl;
	assign union_top    = kind ? 16'sd0 : gt;
	assign union_width  = kind ? 17'd0 : gw;
	assign union_height = kind ? 17'd0 : gh;
	assign overflow     = ovf;
	assign last_record  = last_r;
endmodule
`default_nettype wire

// ----- rtl/abg_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// abg_datapath
// Box stores, union-find parent table, group accumulators and gap test.
// ----------------------------------------------------------------------------
module abg_datapath (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire abg_pkg::abg_cmd_t              cmd,
	output abg_pkg::abg_sts_t                   sts,
	input  wire [15:0]                          gap_x,
	input  wire [15:0]                          gap_y,
	input  wire signed [abg_pkg::COORD_BITS-1:0] in_left,
	input  wire signed [abg_pkg::COORD_BITS-1:0] in_top,
	input  wire signed [abg_pkg::COORD_BITS-1:0] in_width,
	input  wire signed [abg_pkg::COORD_BITS-1:0] in_height,
	input  wire [abg_pkg::IDX_BITS-1:0]         wr_idx,
	input  wire [abg_pkg::IDX_BITS-1:0]         grp_sel,
	input  wire [abg_pkg::IDX_BITS-1:0]         mem_sel,
	output logic [abg_pkg::IDX_BITS-1:0]        mem_group,
	output logic signed [abg_pkg::COORD_BITS-1:0] grp_left,
	output logic signed [abg_pkg::COORD_BITS-1:0] grp_top,
	output logic [abg_pkg::EDGE_BITS-1:0]       grp_width,
	output logic [abg_pkg::EDGE_BITS-1:0]       grp_height,
	output logic [abg_pkg::CNT_BITS-1:0]        grp_count
);
	localparam int CB = abg_pkg::COORD_BITS;
	localparam int SB = abg_pkg::SIZE_BITS;
	localparam int EB = abg_pkg::EDGE_BITS;
	localparam int GB = abg_pkg::GAP_BITS;
	localparam int IB = abg_pkg::IDX_BITS;
	localparam int NB = abg_pkg::CNT_BITS;
	localparam int MB = abg_pkg::MAX_BOXES;

	// box memories
	logic signed [CB-1:0] left_mem   [MB];
	logic signed [CB-1:0] top_mem    [MB];
	logic        [SB-1:0] width_mem  [MB];
	logic        [SB-1:0] height_mem [MB];

	logic signed [CB-1:0] a_l_q, a_t_q, b_l_q, b_t_q;
	logic        [SB-1:0] a_w_q, a_h_q, b_w_q, b_h_q;

	logic [SB-1:0] cw, ch;
	assign cw = in_width[CB-1]  ? '0 : in_width[SB-1:0];
	assign ch = in_height[CB-1] ? '0 : in_height[SB-1:0];

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			left_mem[wr_idx]   <= in_left;
			top_mem[wr_idx]    <= in_top;
			width_mem[wr_idx]  <= cw;
			height_mem[wr_idx] <= ch;
		end
		if (cmd.rd_i) begin
			a_l_q <= left_mem[cmd.i];
			a_t_q <= top_mem[cmd.i];
			a_w_q <= width_mem[cmd.i];
			a_h_q <= height_mem[cmd.i];
		end
		if (cmd.rd_j) begin
			b_l_q <= left_mem[cmd.j];
			b_t_q <= top_mem[cmd.j];
			b_w_q <= width_mem[cmd.j];
			b_h_q <= height_mem[cmd.j];
		end
	end

	// gap test on registered pair
	function automatic logic signed [GB-1:0] gap_f(
		input logic signed [CB-1:0] la, input logic [SB-1:0] wa,
		input logic signed [CB-1:0] lb, input logic [SB-1:0] wb);
		logic signed [GB-1:0] g1, g2, g;
		g1 = GB'(la) - (GB'(lb) + $signed({{(GB-SB){1'b0}}, wb}));
		g2 = GB'(lb) - (GB'(la) + $signed({{(GB-SB){1'b0}}, wa}));
		g  = (g1 > g2) ? g1 : g2;
		gap_f = (g > 0) ? g : '0;
	endfunction

	logic signed [GB-1:0] gx, gy;
	assign gx = gap_f(a_l_q, a_w_q, b_l_q, b_w_q);
	assign gy = gap_f(a_t_q, a_h_q, b_t_q, b_h_q);

	logic linked_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) linked_q <= 1'b0;
		else if (cmd.test)
			linked_q <= (gx < $signed({2'b00, gap_x})) && (gy < $signed({2'b00, gap_y}));
	end

	// parent table with path halving, one step per cycle
	logic [IB-1:0] parent_q [MB];
	logic [IB-1:0] cur_q;
	logic          busy_q;
	logic [IB-1:0] fstart, fp, fpp;
	assign fstart = busy_q ? cur_q : cmd.i;
	assign fp     = parent_q[fstart];
	assign fpp    = parent_q[fp];
	logic fdone;
	assign fdone = (fp == fstart);

	// slot table and group accumulators
	logic [MB-1:0]        slot_vld_q;
	logic [IB-1:0]        slot_q   [MB];
	logic [IB-1:0]        box_grp_q[MB];
	logic signed [EB-1:0] gl_q [MB], gt_q [MB], gr_q [MB], gb_q [MB];
	logic [NB-1:0]        cnt_q [MB];
	logic [NB-1:0]        ngroups_q;
	logic [IB-1:0]        s;
	logic signed [EB-1:0] bl, bt, br, bb;

	assign bl = EB'(a_l_q);
	assign bt = EB'(a_t_q);
	assign br = EB'(a_l_q) + $signed({2'b00, a_w_q});
	assign bb = EB'(a_t_q) + $signed({2'b00, a_h_q});
	assign s  = slot_vld_q[cur_q] ? slot_q[cur_q] : ngroups_q[IB-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MB; k++) parent_q[k] <= IB'(k);
			slot_vld_q <= '0;
			ngroups_q  <= '0;
			busy_q     <= 1'b0;
			cur_q      <= '0;
		end else if (cmd.clear) begin
			for (int k = 0; k < MB; k++) parent_q[k] <= IB'(k);
			slot_vld_q <= '0;
			ngroups_q  <= '0;
			busy_q     <= 1'b0;
		end else begin
			if (cmd.find_i) begin
				if (fdone) begin
					busy_q <= 1'b0;
					cur_q  <= fstart;
				end else begin
					parent_q[fstart] <= fpp;
					cur_q  <= fpp;
					busy_q <= 1'b1;
				end
			end
			// root of i hangs under the root of j found this cycle
			if (cmd.link) parent_q[cmd.j] <= fstart;
			if (cmd.slot_upd) begin
				if (!slot_vld_q[cur_q]) begin
					slot_vld_q[cur_q] <= 1'b1;
					slot_q[cur_q]     <= ngroups_q[IB-1:0];
					ngroups_q         <= ngroups_q + 1'b1;
				end
			end
		end
	end

	// accumulator payload
	always_ff @(posedge clk) begin
		if (cmd.slot_upd) begin
			box_grp_q[cmd.i] <= s;
			if (!slot_vld_q[cur_q]) begin
				gl_q[s] <= bl; gt_q[s] <= bt; gr_q[s] <= br; gb_q[s] <= bb;
				cnt_q[s] <= NB'(1);
			end else begin
				if (bl < gl_q[s]) gl_q[s] <= bl;
				if (bt < gt_q[s]) gt_q[s] <= bt;
				if (br > gr_q[s]) gr_q[s] <= br;
				if (bb > gb_q[s]) gb_q[s] <= bb;
				cnt_q[s] <= cnt_q[s] + 1'b1;
			end
		end
	end

	logic signed [EB-1:0] dw, dh;
	assign dw = gr_q[grp_sel] - gl_q[grp_sel];
	assign dh = gb_q[grp_sel] - gt_q[grp_sel];
	assign grp_left   = gl_q[grp_sel][CB-1:0];
	assign grp_top    = gt_q[grp_sel][CB-1:0];
	assign grp_width  = dw;
	assign grp_height = dh;
	assign grp_count  = cnt_q[grp_sel];
	assign mem_group  = box_grp_q[mem_sel];

	// status back to the controller
	always_comb begin
		sts.linked    = linked_q;
		sts.find_done = fdone;
		sts.root      = fstart;
		sts.ngroups   = ngroups_q;
	end
endmodule
`default_nettype wire

// ----- rtl/abg_control.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// abg_control
// Sequencer for load, pair linking, group pass and record output.
// ----------------------------------------------------------------------------
module abg_control (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_fire,
	input  wire                          in_last,
	output logic                         in_ready,
	output abg_pkg::abg_cmd_t            cmd,
	input  wire abg_pkg::abg_sts_t       sts,
	output logic [abg_pkg::IDX_BITS-1:0] wr_idx,
	output logic                         ovf,
	output logic [abg_pkg::IDX_BITS-1:0] out_grp,
	output logic [abg_pkg::IDX_BITS-1:0] out_mem,
	input  wire  [abg_pkg::IDX_BITS-1:0] mem_group,
	input  wire  [abg_pkg::CNT_BITS-1:0] grp_count,
	output logic                         rec_valid,
	output logic                         rec_kind,
	output logic                         rec_last,
	input  wire                          rec_stall
);
	localparam int IB = abg_pkg::IDX_BITS;
	localparam int NB = abg_pkg::CNT_BITS;

	localparam logic [3:0] ST_LOAD  = 4'd0;
	localparam logic [3:0] ST_RD    = 4'd1;
	localparam logic [3:0] ST_TEST  = 4'd2;
	localparam logic [3:0] ST_CHK   = 4'd3;
	localparam logic [3:0] ST_FI    = 4'd4;
	localparam logic [3:0] ST_FJ    = 4'd5;
	localparam logic [3:0] ST_NEXT  = 4'd6;
	localparam logic [3:0] ST_GRD   = 4'd7;
	localparam logic [3:0] ST_GFIND = 4'd8;
	localparam logic [3:0] ST_GUPD  = 4'd9;
	localparam logic [3:0] ST_HDR   = 4'd10;
	localparam logic [3:0] ST_MEM   = 4'd11;
	localparam logic [3:0] ST_CLR   = 4'd12;

	logic [3:0]    state_q;
	logic [NB-1:0] n_q;
	logic [IB-1:0] i_q, j_q, ri_q, g_q, m_q;
	logic          ovf_q;

	// last member of a group: scan ahead is avoided by counting members
	logic [NB-1:0] left_q;

	assign wr_idx  = n_q[IB-1:0];
	assign ovf     = ovf_q;
	assign out_grp = g_q;
	assign out_mem = m_q;
	assign in_ready = (state_q == ST_LOAD);

	always_comb begin
		cmd = '0;
		cmd.i = i_q;
		cmd.j = j_q;
		cmd.store = in_fire && (n_q < NB'(abg_pkg::MAX_BOXES));
		case (state_q)
			ST_RD:    begin cmd.rd_i = 1'b1; cmd.rd_j = 1'b1; end
			ST_TEST:  cmd.test = 1'b1;
			ST_FI:    cmd.find_i = 1'b1;
			ST_FJ:    begin cmd.find_i = 1'b1; cmd.i = j_q;
				cmd.j = ri_q; cmd.link = sts.find_done; end
			ST_GRD:   cmd.rd_i = 1'b1;
			ST_GFIND: cmd.find_i = 1'b1;
			ST_GUPD:  cmd.slot_upd = 1'b1;
			ST_CLR:   cmd.clear = 1'b1;
			default:  ;
		endcase
	end

	// member records of current group
	logic is_mem;
	assign is_mem = (mem_group == g_q);
	assign rec_valid = (state_q == ST_HDR) || (state_q == ST_MEM && is_mem);
	assign rec_kind  = (state_q == ST_MEM) ? abg_pkg::KIND_MEMBER : abg_pkg::KIND_HEADER;
	assign rec_last  = (state_q == ST_MEM) && (left_q == NB'(1))
		&& (NB'(g_q) + 1'b1 == sts.ngroups);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			n_q <= '0; i_q <= '0; j_q <= '0; ri_q <= '0;
			g_q <= '0; m_q <= '0; ovf_q <= 1'b0; left_q <= '0;
		end else begin
			case (state_q)
				ST_LOAD: if (in_fire) begin
					if (n_q < NB'(abg_pkg::MAX_BOXES)) n_q <= n_q + 1'b1;
					else ovf_q <= 1'b1;
					if (in_last) begin
						i_q <= '0; j_q <= IB'(1);
						// a single stored box has no pairs to check
						state_q <= (n_q != '0) ? ST_RD : ST_GRD;
					end
				end
				ST_RD:   state_q <= ST_TEST;
				ST_TEST: state_q <= ST_CHK;
				ST_CHK:  state_q <= sts.linked ? ST_FI : ST_NEXT;
				ST_FI:   if (sts.find_done) begin ri_q <= sts.root; state_q <= ST_FJ; end
				ST_FJ:   if (sts.find_done) state_q <= ST_NEXT;
				ST_NEXT: begin
					if (NB'(j_q) + 1'b1 < n_q) begin
						j_q <= j_q + 1'b1; state_q <= ST_RD;
					end else if (NB'(i_q) + NB'(2) < n_q) begin
						i_q <= i_q + 1'b1; j_q <= i_q + IB'(2); state_q <= ST_RD;
					end else begin
						i_q <= '0; state_q <= ST_GRD;
					end
				end
				ST_GRD:   state_q <= ST_GFIND;
				ST_GFIND: if (sts.find_done) state_q <= ST_GUPD;
				ST_GUPD: begin
					if (NB'(i_q) + 1'b1 < n_q) begin
						i_q <= i_q + 1'b1; state_q <= ST_GRD;
					end else begin
						g_q <= '0; state_q <= ST_HDR;
					end
				end
				ST_HDR: if (!rec_stall) begin
					m_q <= '0; left_q <= grp_count; state_q <= ST_MEM;
				end
				ST_MEM: if (!(is_mem && rec_stall)) begin
					if (is_mem) left_q <= left_q - 1'b1;
					if (NB'(m_q) + 1'b1 < n_q) m_q <= m_q + 1'b1;
					else if (NB'(g_q) + 1'b1 < sts.ngroups) begin
						g_q <= g_q + 1'b1; state_q <= ST_HDR;
					end else state_q <= ST_CLR;
				end
				ST_CLR: begin
					n_q <= '0; ovf_q <= 1'b0; i_q <= '0; state_q <= ST_LOAD;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule
`default_nettype wire
